// ===== hdl/folded_depth_to_jet_color_unit_defines.svh =====
// Assertion macros for the folded depth to jet color unit.
// Included by the modules that carry concurrent checks; needs clk and arst_n in scope.
`ifndef FOLDED_DEPTH_TO_JET_COLOR_UNIT_DEFINES_SVH
`define FOLDED_DEPTH_TO_JET_COLOR_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define FDJC_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("fdjc check failed");
`define FDJC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) \
		else $error("fdjc check failed");
`else
`define FDJC_ASSERT(lbl, prop)
`define FDJC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== hdl/fdjc_pkg.sv =====
// Shared types and constants of the folded depth to jet color unit.
// No dependencies.
package fdjc_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int DEPTH_W    = 32;
	localparam int PER_W      = 31;
	localparam int COL_W      = 8;
	localparam int FOLD_W     = FRAC_BITS + 1;
	localparam int MOD_CELLS  = DEPTH_W;
	localparam int FOLD_CELLS = FRAC_BITS + 1;
	localparam int MAP_W      = FRAC_BITS + 13;

	localparam logic [PER_W-1:0] PER_RESET = PER_W'(1) << FRAC_BITS;
	localparam logic [FOLD_W-1:0] FOLD_ONE = FOLD_W'(1) << FRAC_BITS;
	localparam logic [COL_W-1:0] RED_PEAK = COL_W'(204);

	typedef struct packed {
		logic               vld;
		logic [PER_W-1:0]   rem;
		logic [DEPTH_W-1:0] acc;
		logic               neg;
		logic               nz;
	} div_beat_t;

	typedef struct packed {
		logic             vld;
		logic [COL_W-1:0] red;
		logic [COL_W-1:0] green;
		logic [COL_W-1:0] blue;
	} color_t;

endpackage

// ===== hdl/folded_depth_to_jet_color_unit.sv =====
// Folded depth to jet color unit, top level.
// Uses fdjc_pkg, fdjc_div_cell, fdjc_jet and the assertion macro header.
//
// One depth beat in, one RGB beat out, a new beat accepted every cycle while in_stall is
// low. From input accept to output valid a beat passes an entry register, a row of 32
// division cells that reduce the depth modulo fold_period one bit per cell, two registers
// that form the folded numerator, a row of 17 cells that divide it by the period into the
// folded fraction, the colormap register and the output register. A one-entry skid
// behind the output register absorbs the beat in flight when out_stall rises; in_stall
// is that skid's full flag, straight from a flop. Write fold_period only while idle.
`include "folded_depth_to_jet_color_unit_defines.svh"
module folded_depth_to_jet_color_unit import fdjc_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [PER_W-1:0]          cfg_wr_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic signed [DEPTH_W-1:0] depth,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [COL_W-1:0]          red,
	output logic [COL_W-1:0]          green,
	output logic [COL_W-1:0]          blue
);

	logic [PER_W-1:0] fold_period_q;
	logic [PER_W-1:0] per;
	logic             adv;
	logic             skid_full_q;
	logic             out_valid_q;
	color_t           out_q;
	color_t           skid_q;
	color_t           color_s4;
	div_beat_t        ent_s1;
	div_beat_t        zsel_s2;
	div_beat_t        mod_c [MOD_CELLS+1];
	div_beat_t        fold_c [FOLD_CELLS+1];
	div_beat_t        ent_nxt;
	div_beat_t        zsel_nxt;
	div_beat_t        numr_nxt;
	logic [PER_W-1:0] r_mod;
	logic [PER_W-1:0] z_val;
	logic [PER_W:0]   two_z;
	logic [PER_W:0]   mirr;
	logic [PER_W:0]   numr;
	logic             out_take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_period_q <= PER_RESET;
		end else if (cfg_wr_en) begin
			fold_period_q <= cfg_wr_data;
		end
	end

	assign per      = (fold_period_q == '0) ? PER_W'(1) : fold_period_q;
	assign adv      = !skid_full_q;
	assign in_stall = skid_full_q;

	always_comb begin
		ent_nxt.vld = in_valid;
		ent_nxt.rem = '0;
		ent_nxt.acc = depth[DEPTH_W-1] ? (~depth + DEPTH_W'(1)) : depth;
		ent_nxt.neg = depth[DEPTH_W-1];
		ent_nxt.nz  = |depth;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_s1.vld <= 1'b0;
		end else if (adv) begin
			ent_s1 <= ent_nxt;
		end
	end

	assign mod_c[0] = ent_s1;

	for (genvar i = 0; i < MOD_CELLS; i++) begin : g_mod
		fdjc_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.per    (per),
			.din    (mod_c[i]),
			.dout   (mod_c[i+1])
		);
	end

	always_comb begin
		r_mod = mod_c[MOD_CELLS].rem;
		if (mod_c[MOD_CELLS].neg) begin
			z_val = (r_mod == '0) ? '0 : per - r_mod;
		end else begin
			z_val = ((r_mod == '0) && mod_c[MOD_CELLS].nz) ? per : r_mod;
		end
		zsel_nxt     = mod_c[MOD_CELLS];
		zsel_nxt.rem = z_val;
		zsel_nxt.acc = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zsel_s2.vld <= 1'b0;
		end else if (adv) begin
			zsel_s2 <= zsel_nxt;
		end
	end

	always_comb begin
		two_z = {zsel_s2.rem, 1'b0};
		mirr  = {per, 1'b0} - two_z;
		numr  = (two_z > {1'b0, per}) ? mirr : two_z;
		numr_nxt.vld = zsel_s2.vld;
		numr_nxt.rem = {1'b0, numr[PER_W-1:1]};
		numr_nxt.acc = {numr[0], {(DEPTH_W-1){1'b0}}};
		numr_nxt.neg = 1'b0;
		numr_nxt.nz  = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fold_c[0].vld <= 1'b0;
		end else if (adv) begin
			fold_c[0] <= numr_nxt;
		end
	end

	for (genvar j = 0; j < FOLD_CELLS; j++) begin : g_fold
		fdjc_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.per    (per),
			.din    (fold_c[j]),
			.dout   (fold_c[j+1])
		);
	end

	fdjc_jet u_jet (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.din    (fold_c[FOLD_CELLS]),
		.dout   (color_s4)
	);

	assign out_take = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else if (skid_full_q) begin
			if (out_take) begin
				out_q       <= skid_q;
				skid_full_q <= 1'b0;
			end
		end else if (color_s4.vld) begin
			if (!out_valid_q || out_take) begin
				out_q       <= color_s4;
				out_valid_q <= 1'b1;
			end else begin
				skid_q      <= color_s4;
				skid_full_q <= 1'b1;
			end
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign red       = out_q.red;
	assign green     = out_q.green;
	assign blue      = out_q.blue;

	`FDJC_ASSERT(a_skid_has_out, skid_full_q |-> out_valid_q)
	`FDJC_ASSERT_NEXT(a_accept_enters, in_valid && !in_stall, ent_s1.vld)
	`FDJC_ASSERT(a_rem_below_per, mod_c[MOD_CELLS].vld |-> mod_c[MOD_CELLS].rem < per)
	`FDJC_ASSERT(a_fold_in_range, fold_c[FOLD_CELLS].vld |-> fold_c[FOLD_CELLS].acc[FOLD_W-1:0] <= FOLD_ONE)
	`FDJC_ASSERT(a_red_peak, out_valid_q |-> out_q.red <= RED_PEAK)

endmodule

// ===== hdl/fdjc_div_cell.sv =====
// One restoring-division cell: shifts in one dividend bit, subtracts the period when the trial remainder reaches it.
// Depends on fdjc_pkg.
module fdjc_div_cell import fdjc_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [PER_W-1:0] per,
	input  div_beat_t        din,
	output div_beat_t        dout
);

	logic [PER_W:0]   trial;
	logic             ge;
	logic [PER_W:0]   diff;
	div_beat_t        nxt;

	always_comb begin
		trial = {din.rem, din.acc[DEPTH_W-1]};
		ge    = trial >= {1'b0, per};
		diff  = trial - {1'b0, per};
		nxt     = din;
		nxt.rem = ge ? diff[PER_W-1:0] : trial[PER_W-1:0];
		nxt.acc = {din.acc[DEPTH_W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout.vld <= 1'b0;
		end else if (en) begin
			dout <= nxt;
		end
	end

endmodule

// ===== hdl/fdjc_jet.sv =====
// Jet colormap stage: five linear segments over the folded value, registered.
// Depends on fdjc_pkg.
module fdjc_jet import fdjc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  div_beat_t din,
	output color_t    dout
);

	localparam logic [MAP_W-1:0] X1 = MAP_W'(1) << FRAC_BITS;
	localparam logic [MAP_W-1:0] X3 = MAP_W'(3) << FRAC_BITS;
	localparam logic [MAP_W-1:0] X5 = MAP_W'(5) << FRAC_BITS;
	localparam logic [MAP_W-1:0] X7 = MAP_W'(7) << FRAC_BITS;
	localparam logic [MAP_W-1:0] B0 = MAP_W'(255) << FRAC_BITS;
	localparam logic [MAP_W-1:0] R4 = MAP_W'(2193) << FRAC_BITS;

	logic [MAP_W-1:0] f;
	logic [MAP_W-1:0] f8;
	logic [MAP_W-1:0] r_full;
	logic [MAP_W-1:0] g_full;
	logic [MAP_W-1:0] b_full;
	color_t           nxt;

	always_comb begin
		f      = MAP_W'(din.acc[FOLD_W-1:0]);
		f8     = f << 3;
		r_full = '0;
		g_full = '0;
		b_full = '0;
		if (f8 < X1) begin
			b_full = B0 + MAP_W'(2040) * f;
		end else if (f8 < X3) begin
			g_full = MAP_W'(255) * (f8 - X1);
			b_full = B0 << 1;
		end else if (f8 < X5) begin
			r_full = MAP_W'(204) * (f8 - X3);
			g_full = B0 << 1;
			b_full = MAP_W'(255) * (X5 - f8);
		end else if (f8 < X7) begin
			r_full = MAP_W'(204) << (FRAC_BITS + 1);
			g_full = MAP_W'(255) * (X7 - f8);
		end else begin
			r_full = R4 - MAP_W'(2040) * f;
		end
		nxt.vld   = din.vld;
		nxt.red   = r_full[FRAC_BITS+1 +: COL_W];
		nxt.green = g_full[FRAC_BITS+1 +: COL_W];
		nxt.blue  = b_full[FRAC_BITS+1 +: COL_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout.vld <= 1'b0;
		end else if (en) begin
			dout <= nxt;
		end
	end

endmodule

// ===== dv/folded_depth_to_jet_color_unit_tb.sv =====
// Testbench for folded_depth_to_jet_color_unit: streams depth beats under several fold periods
// and compares every RGB beat with a cycle-free model of the fold and the jet colormap.
// Depends on fdjc_pkg and the unit's RTL.
module folded_depth_to_jet_color_unit_tb;
	import fdjc_pkg::*;

	typedef struct packed {
		logic [COL_W-1:0] red;
		logic [COL_W-1:0] green;
		logic [COL_W-1:0] blue;
	} rgb_t;

	localparam int BEATS_PER_PERIOD = 187;
	localparam int DRAIN_CYCLES     = 4000;
	localparam int TAIL_CYCLES      = 60;

	logic                      clk         = 1'b0;
	logic                      arst_n      = 1'b0;
	logic                      cfg_wr_en   = 1'b0;
	logic [PER_W-1:0]          cfg_wr_data = '0;
	logic                      in_valid    = 1'b0;
	logic                      in_stall;
	logic signed [DEPTH_W-1:0] depth       = '0;
	logic                      out_valid;
	logic                      out_stall   = 1'b0;
	logic [COL_W-1:0]          red;
	logic [COL_W-1:0]          green;
	logic [COL_W-1:0]          blue;

	logic [DEPTH_W-1:0] depth_backlog[$];
	rgb_t               colors_due[$];
	rgb_t               want;
	logic [PER_W-1:0]   period_now  = PER_RESET;
	bit                 idle_en     = 1'b0;
	int                 send_gap    = 0;
	int                 stall_left  = 0;
	int                 mismatches  = 0;
	int                 beats_in    = 0;
	int                 colors_seen = 0;
	int                 periods_run = 0;

	folded_depth_to_jet_color_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.depth       (depth),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.red         (red),
		.green       (green),
		.blue        (blue)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic rgb_t jet_of_depth(input logic [DEPTH_W-1:0] d, input logic [PER_W-1:0] per);
		longint          dd;
		longint          p;
		longint          z;
		longint unsigned one;
		longint unsigned uz;
		longint unsigned up;
		longint unsigned x;
		longint unsigned r;
		longint unsigned g;
		longint unsigned b;
		rgb_t            c;
		dd  = longint'($signed(d));
		p   = longint'(per);
		if (p == 0)
			p = 1;
		one = 64'd1 << FRAC_BITS;
		z   = dd % p;
		if (z < 0)
			z = z + p;
		if (dd > 0 && z == 0)
			z = p;
		uz = z;
		up = p;
		if (2 * uz > up)
			x = ((2 * up - 2 * uz) * one) / up;
		else
			x = (2 * uz * one) / up;
		if (8 * x < one) begin
			r = 0;
			g = 0;
			b = (255 * one + 2040 * x) / (2 * one);
		end else if (8 * x < 3 * one) begin
			r = 0;
			g = (255 * (8 * x - one)) / (2 * one);
			b = 255;
		end else if (8 * x < 5 * one) begin
			r = (204 * (8 * x - 3 * one)) / (2 * one);
			g = 255;
			b = (255 * (5 * one - 8 * x)) / (2 * one);
		end else if (8 * x < 7 * one) begin
			r = 204;
			g = (255 * (7 * one - 8 * x)) / (2 * one);
			b = 0;
		end else begin
			r = (2193 * one - 2040 * x) / (2 * one);
			g = 0;
			b = 0;
		end
		c.red   = COL_W'(r);
		c.green = COL_W'(g);
		c.blue  = COL_W'(b);
		return c;
	endfunction

	// Mostly depths near multiples of the period and near the colormap breakpoints.
	function automatic logic [DEPTH_W-1:0] pick_depth(input longint p);
		longint k;
		longint spot;
		int     mode;
		mode = $urandom_range(0, 9);
		k    = longint'($urandom_range(0, 16)) - 8;
		spot = k * p + (p * longint'($urandom_range(0, 16))) / 16;
		if (mode < 3)
			return $urandom;
		else if (mode < 7)
			spot = spot + longint'($urandom_range(0, 6)) - 3;
		else
			spot = spot + longint'($urandom_range(0, 1023)) - 512;
		return DEPTH_W'(spot);
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t mismatch: %s", $time, what);
		mismatches++;
	endtask

	task automatic drain_colors();
		int waited;
		waited = 0;
		while (depth_backlog.size() != 0 || in_valid)
			@(negedge clk);
		while (colors_due.size() != 0 && waited < DRAIN_CYCLES) begin
			@(negedge clk);
			waited++;
		end
		if (colors_due.size() != 0) begin
			report_mismatch($sformatf("%0d colors never arrived", colors_due.size()));
			colors_due.delete();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			depth    <= '0;
			send_gap <= 0;
		end else if (!in_valid || !in_stall) begin
			if (send_gap > 0) begin
				in_valid <= 1'b0;
				send_gap <= send_gap - 1;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				in_valid <= 1'b0;
				send_gap <= $urandom_range(1, 17) - 1;
			end else if (depth_backlog.size() != 0) begin
				in_valid <= 1'b1;
				depth    <= depth_backlog.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall  <= 1'b0;
			stall_left <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				colors_due.insert(colors_due.size(), jet_of_depth(depth, period_now));
				beats_in++;
			end
			if (out_valid && !out_stall) begin
				colors_seen++;
				if (colors_due.size() == 0) begin
					report_mismatch($sformatf("color %0d/%0d/%0d with no depth beat behind it",
						red, green, blue));
				end else begin
					want = colors_due.pop_front();
					if (red !== want.red)
						report_mismatch($sformatf("red %0d, want %0d", red, want.red));
					if (green !== want.green)
						report_mismatch($sformatf("green %0d, want %0d", green, want.green));
					if (blue !== want.blue)
						report_mismatch($sformatf("blue %0d, want %0d", blue, want.blue));
				end
			end
			if (stall_left > 0) begin
				out_stall  <= 1'b1;
				stall_left <= stall_left - 1;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				out_stall  <= 1'b1;
				stall_left <= $urandom_range(1, 17) - 1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		int unsigned periods[$];
		int unsigned edge_depths[$];
		longint      p;
		periods     = '{32'h0001_0000, 1, 0, 32'h7FFF_FFFF, 3, 0, 32'h000A_0000, 100};
		periods[5]  = $urandom_range(32'h7FFF_FFFF, 1);
		// reset period is 1.0: fold peak at 0.5, breakpoints at 1/16, 3/16, 5/16, 7/16
		edge_depths = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0002_0000, 32'h0000_8000,
			32'h0000_7FFF, 32'h0000_8001, 32'h0000_1000, 32'h0000_0FFF, 32'h0000_3000,
			32'h0000_5000, 32'h0000_7000, 32'h0000_6FFF, 32'h0000_C000, 32'h0000_FFFF,
			32'hFFFF_8000};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < periods.size(); ph++) begin
			if (ph > 0) begin
				@(posedge clk);
				cfg_wr_en   <= 1'b1;
				cfg_wr_data <= PER_W'(periods[ph]);
				period_now = PER_W'(periods[ph]);
				@(posedge clk);
				cfg_wr_en   <= 1'b0;
			end
			idle_en = (ph < periods.size() - 1);
			periods_run++;
			if (ph == 0)
				foreach (edge_depths[i])
					depth_backlog.insert(depth_backlog.size(), edge_depths[i]);
			p = (period_now == 0) ? 1 : longint'(period_now);
			depth_backlog.insert(depth_backlog.size(), DEPTH_W'(p));
			depth_backlog.insert(depth_backlog.size(), DEPTH_W'(-p));
			depth_backlog.insert(depth_backlog.size(), DEPTH_W'(p / 2));
			depth_backlog.insert(depth_backlog.size(), DEPTH_W'(p / 2 + 1));
			depth_backlog.insert(depth_backlog.size(), DEPTH_W'(3 * p));
			repeat (BEATS_PER_PERIOD)
				depth_backlog.insert(depth_backlog.size(), pick_depth(p));
			drain_colors();
		end
		repeat (TAIL_CYCLES) @(negedge clk);
		$display("%0d depth beats sent under %0d fold periods, %0d colors compared",
			beats_in, periods_run, colors_seen);
		$display("fold periods included reset, one LSB, zero and the 31-bit maximum");
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#(12 * 600000);
		$display("timeout with %0d colors outstanding", colors_due.size());
		$display("simulation failed");
		$finish;
	end

endmodule

// ===== folded_depth_to_jet_color_unit.f =====
+incdir+hdl
hdl/fdjc_pkg.sv
hdl/fdjc_div_cell.sv
hdl/fdjc_jet.sv
hdl/folded_depth_to_jet_color_unit.sv
dv/folded_depth_to_jet_color_unit_tb.sv
